// ===== sv/tcc_pkg.sv =====
// tcc_pkg: shared constants and types for the t-way combination counter
// no dependencies; used by tcc_lane and t_way_combination_counter

package tcc_pkg;

    localparam int MAX_T    = 8;
    localparam int LEVEL_W  = 16;
    localparam int SUM_W    = 64;
    localparam int STR_W    = 4;
    localparam int IDX_W    = (MAX_T > 1) ? $clog2(MAX_T) : 1;

    localparam logic [STR_W-1:0] STRENGTH_RESET = STR_W'(2);
    localparam logic [STR_W-1:0] STRENGTH_MAX   = STR_W'(MAX_T);

    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // per-lane update control, common to every lane
    typedef struct packed {
        logic advance;
        logic clear;
    } lane_ctrl_t;

endpackage

// ===== sv/tcc_lane.sv =====
// tcc_lane: one running sum e_k, updated as e_k += e_(k-1) * level
// depends on tcc_pkg

module tcc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  tcc_pkg::lane_ctrl_t ctrl,
    input  tcc_pkg::sum_t       prev_sum,
    input  tcc_pkg::level_t     level,
    output tcc_pkg::sum_t       sum,
    output tcc_pkg::sum_t       sum_next
);

    tcc_pkg::sum_t sum_reg;
    tcc_pkg::sum_t prod;

    // product wraps to the sum width
    assign prod     = tcc_pkg::SUM_W'(prev_sum * tcc_pkg::SUM_W'(level));
    assign sum_next = sum_reg + prod;
    assign sum      = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            if (ctrl.clear)
            begin
                sum_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
            end
        end
    end

endmodule

// ===== sv/t_way_combination_counter.sv =====
// t_way_combination_counter: top level, streams levels and returns e_t per set
// depends on tcc_pkg and tcc_lane
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | level, last, in_valid / in_stall     | in
//  result   | count, out_valid / out_stall         | out
//  config   | cfg_we, cfg_wdata (strength)         | in
//
// one level a cycle unless the input stalls: the input register feeds all MAX_T lanes,
// each one multiply-accumulate wide, which update together from their previous values
// a count is loaded into the result register as its last item leaves the input register
// reset clears the sums and the valid flags and sets strength to 2
// the input stalls only when a last item waits in the input register while
// the result register is full and stalled

module t_way_combination_counter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tcc_pkg::LEVEL_W-1:0]     level,
    input  logic                            last,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic [tcc_pkg::SUM_W-1:0]       count,
    output logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            cfg_we,
    input  logic [tcc_pkg::STR_W-1:0]       cfg_wdata
);

    logic [tcc_pkg::STR_W-1:0] strength_reg;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    tcc_pkg::level_t level_reg;
    logic            last_reg;
    logic            s1_adv;
    logic            in_xfer;

    tcc_pkg::lane_ctrl_t lane_ctrl;
    tcc_pkg::sum_t       lane_prev [tcc_pkg::MAX_T];
    tcc_pkg::sum_t       lane_sum  [tcc_pkg::MAX_T];
    tcc_pkg::sum_t       lane_next [tcc_pkg::MAX_T];

    logic [tcc_pkg::STR_W-1:0] eff_t;
    logic [tcc_pkg::STR_W-1:0] t_minus1;
    logic [tcc_pkg::IDX_W-1:0] sel_idx;
    tcc_pkg::sum_t             count_sel;

    logic          out_valid_reg;
    logic          out_valid_next;
    tcc_pkg::sum_t count_reg;
    logic          out_load;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= tcc_pkg::STRENGTH_RESET;
        end
        else if (cfg_we)
        begin
            strength_reg <= cfg_wdata;
        end
    end

    // input register
    assign s1_adv   = s1_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            level_reg <= level;
            last_reg  <= last;
        end
    end

    // sum lanes, e_0 is the constant one
    assign lane_ctrl.advance = s1_adv;
    assign lane_ctrl.clear   = last_reg;

    for (genvar k = 0; k < tcc_pkg::MAX_T; k++)
    begin : g_lane
        if (k == 0)
        begin : g_first
            assign lane_prev[k] = tcc_pkg::SUM_W'(1);
        end
        else
        begin : g_rest
            assign lane_prev[k] = lane_sum[k-1];
        end

        tcc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .prev_sum (lane_prev[k]),
            .level    (level_reg),
            .sum      (lane_sum[k]),
            .sum_next (lane_next[k])
        );
    end

    // strength above MAX_T saturates, zero gives the empty product
    assign eff_t    = (strength_reg > tcc_pkg::STRENGTH_MAX) ? tcc_pkg::STRENGTH_MAX
                                                             : strength_reg;
    assign t_minus1 = eff_t - tcc_pkg::STR_W'(1);
    assign sel_idx  = t_minus1[tcc_pkg::IDX_W-1:0];

    always_comb
    begin
        if (eff_t == '0)
        begin
            count_sel = tcc_pkg::SUM_W'(1);
        end
        else
        begin
            count_sel = lane_next[sel_idx];
        end
    end

    // result register
    assign out_load       = s1_adv && last_reg;
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            count_reg <= count_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;

    // checks
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (lane_sum[0] == '0))
        else $error("sums not cleared after the last item of a set");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && last_reg))
        else $error("result raised without a last item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("held result overwritten");

    a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
        eff_t <= tcc_pkg::STRENGTH_MAX)
        else $error("effective strength out of range");

endmodule

// ===== sim/tcc_tb_pkg.sv =====
// tcc_tb_pkg: running e_t predictor and count checker for the t-way counter bench
// depends on tcc_pkg for widths and the strength limit
`timescale 1ns / 100ps

package tcc_tb_pkg;

    import tcc_pkg::*;

    class count_predictor;

        sum_t             esym_sums[MAX_T];
        logic [STR_W-1:0] strength;
        sum_t             counts_due[$];
        int               errors;
        int               levels_seen;
        int               counts_checked;

        function new();
            strength       = STRENGTH_RESET;
            errors         = 0;
            levels_seen    = 0;
            counts_checked = 0;
            foreach (esym_sums[k]) esym_sums[k] = '0;
        endfunction

        function void set_strength(logic [STR_W-1:0] value);
            strength = value;
        endfunction

        function int pending();
            return counts_due.size();
        endfunction

        // one level in; on the closing level the selected e_t is queued
        function void note_level(level_t lvl, logic lst);
            int   eff;
            sum_t wide_lvl;
            wide_lvl = sum_t'(lvl);
            levels_seen++;
            for (int k = MAX_T - 1; k >= 1; k--)
                esym_sums[k] = esym_sums[k] + esym_sums[k-1] * wide_lvl;
            esym_sums[0] = esym_sums[0] + wide_lvl;
            if (lst)
            begin
                eff = (strength > STRENGTH_MAX) ? MAX_T : int'(strength);
                counts_due.push_back((eff == 0) ? sum_t'(1) : esym_sums[eff-1]);
                foreach (esym_sums[k]) esym_sums[k] = '0;
            end
        endfunction

        function void check_count(sum_t got);
            sum_t want;
            if (counts_due.size() == 0)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: count transfer with none expected, actual %h", $time, got);
                return;
            end
            want = counts_due.pop_front();
            counts_checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: count mismatch, expected %h actual %h", $time, want, got);
            end
        endfunction

        function void close_out();
            if (counts_due.size() != 0)
            begin
                errors += counts_due.size();
                $display("%0t: %0d counts never arrived, first expected %h",
                         $time, counts_due.size(), counts_due[0]);
            end
        endfunction

    endclass

endpackage

// ===== sim/tb_top.sv =====
// tb_top: stimulus, handshake drivers and timeout for t_way_combination_counter
// depends on tcc_pkg, tcc_tb_pkg and the block under test
`timescale 1ns / 100ps

module tb_top;

    import tcc_pkg::*;
    import tcc_tb_pkg::*;

    localparam int               RANDOM_LEVELS = 400;
    localparam int               QUIET_FROM    = 340;
    localparam int               SETTLE_CYCLES = 6;
    localparam int               CYCLE_LIMIT   = 300000;
    localparam logic [STR_W-1:0] STRENGTH_TOP  = '1;
    localparam logic [STR_W-1:0] STRENGTH_NONE = '0;

    logic             clk;
    logic             rst_n;
    level_t           level;
    logic             last;
    logic             in_valid;
    logic             in_stall;
    sum_t             count;
    logic             out_valid;
    logic             out_stall;
    logic             cfg_we;
    logic [STR_W-1:0] cfg_wdata;

    count_predictor pred;
    bit             quiet;
    bit             tx_gaps;
    bit             rx_gaps;
    int             cycles;
    int             sent;
    int             sets_closed;
    int             strength_writes;

    t_way_combination_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .level     (level),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .count     (count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: sampled at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pred.check_count(count);
    end

    // result side back-pressure in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if (!quiet && rx_gaps && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_level(level_t lvl, logic lst);
        int gap;
        if (!quiet && tx_gaps && $urandom_range(0, 5) == 0)
        begin
            gap      = $urandom_range(1, 15);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        level    = lvl;
        last     = lst;
        do
            @(posedge clk);
        while (in_stall);
        pred.note_level(lvl, lst);
        sent++;
        if (lst)
            sets_closed++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // sender holds off until every count is back and the pipeline is quiet
    task automatic drain();
        in_valid = 1'b0;
        while (pred.pending() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_strength(logic [STR_W-1:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        pred.set_strength(value);
        strength_writes++;
    endtask

    function automatic level_t pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return level_t'($urandom_range(1, 16));
            default: return level_t'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int       len;
        int       n_sets;
        int       stop_at;
        bit       open_end;
        logic [STR_W-1:0] st;

        pred            = new();
        rst_n           = 1'b0;
        level           = '0;
        last            = 1'b0;
        in_valid        = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        quiet           = 1'b0;
        tx_gaps         = 1'b1;
        rx_gaps         = 1'b1;
        cycles          = 0;
        sent            = 0;
        sets_closed     = 0;
        strength_writes = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset strength of two: plain set, too few levels, zero and full levels
        send_level(16'd3, 1'b0);
        send_level(16'd5, 1'b0);
        send_level(16'd7, 1'b1);
        send_level(16'd9, 1'b1);
        send_level('0, 1'b0);
        send_level('1, 1'b0);
        send_level('0, 1'b1);

        // empty subset gives one
        write_strength(STRENGTH_NONE);
        send_level('1, 1'b1);

        write_strength(4'd1);
        send_level('1, 1'b0);
        send_level('1, 1'b0);
        send_level(16'd1, 1'b1);

        // top strength with full levels wraps the 64-bit sum
        write_strength(STRENGTH_MAX);
        for (int i = 0; i < MAX_T; i++)
            send_level('1, i == MAX_T - 1);

        // above the limit saturates; fewer levels than t gives zero
        write_strength(STRENGTH_TOP);
        send_level(16'd2, 1'b0);
        send_level(16'd3, 1'b1);

        // strength changed part way through a set
        write_strength(4'd3);
        send_level(16'd4, 1'b0);
        send_level(16'd5, 1'b0);
        write_strength(4'd1);
        send_level(16'd6, 1'b1);

        stop_at  = sent + RANDOM_LEVELS;
        open_end = 1'b0;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                st = STR_W'($urandom_range(0, 15));
            else
                st = STR_W'($urandom_range(1, MAX_T));
            write_strength(st);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            n_sets  = $urandom_range(1, 6);
            for (int s = 0; s < n_sets && sent < stop_at; s++)
            begin
                len      = $urandom_range(1, (st > 8) ? 11 : int'(st) + 3);
                // now and then leave the set open across a strength change
                open_end = (s == n_sets - 1) && ($urandom_range(0, 5) == 0);
                for (int i = 0; i < len; i++)
                begin
                    if (sent >= stop_at - (RANDOM_LEVELS - QUIET_FROM))
                        quiet = 1'b1;
                    send_level(pick_level(), (i == len - 1) && !open_end);
                end
            end
        end
        // close any set left open
        send_level(pick_level(), 1'b1);

        drain();
        pred.close_out();
        $display("levels sent %0d in %0d closed sets, strength written %0d times",
                 sent, sets_closed, strength_writes);
        $display("counts checked %0d, failures %0d", pred.counts_checked, pred.errors);
        if (pred.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
